FILE: rtl/assert_macros.svh
// assertion macros shared by the zone check modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled while reset is asserted
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("zone check assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("zone check implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("zone check next-cycle implication failed");

`endif

FILE: rtl/lrzc_pkg.sv
// shared constants, types and secant / cosecant tables for the zone check
package lrzc_pkg;

	localparam int SAMPLES_PER_TURN = 1024;
	localparam int SECANT_FRAC_BITS = 12;

	localparam int IDX_W      = 10;
	localparam int RANGE_W    = 16;
	localparam int DIST_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int ENTRY_W   = SECANT_FRAC_BITS + 4;
	localparam int PROD_W    = DIST_W + ENTRY_W;
	localparam int ROM_DEPTH = SAMPLES_PER_TURN / 4 + 1;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int TURN_W    = $clog2(SAMPLES_PER_TURN) + 1;
	localparam int CMP_W     = ((IDX_W > TURN_W) ? IDX_W : TURN_W) + 2;

	localparam logic [63:0] TRIG_ONE   = 64'd1 << 30;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] ROM_MAX    = (64'd16 << SECANT_FRAC_BITS) - 64'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRONT_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ON        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ON       = 2'd3;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef entry_t rom_t [ROM_DEPTH];

	typedef struct packed {
		logic [DIST_W-1:0] front_distance_mm;
		logic [DIST_W-1:0] half_width_mm;
		logic              left_sector_on;
		logic              right_sector_on;
	} cfg_t;

	typedef struct packed {
		logic               checked;
		entry_t             sec_entry;
		entry_t             csc_entry;
		logic [RANGE_W-1:0] range_mm;
		logic               scan_last;
	} stage1_t;

	// restoring long division, only evaluated while the tables are built
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// cosine (odd = 0) or sine (odd = 1) in q30, truncating taylor steps
	function automatic logic [63:0] trig_q30(input logic [63:0] x, input logic odd);
		logic [63:0] term;
		logic [63:0] den;
		longint      sum;
		term = odd ? x : TRIG_ONE;
		sum  = longint'(term);
		for (int j = 1; j <= 20; j++) begin
			if (term != 64'd0) begin
				den  = (64'(2 * j - 1) + 64'(odd)) * (64'(2 * j) + 64'(odd));
				term = div_u64((((term * x) >> 30) * x) >> 30, den);
				if (j % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(TRIG_ONE))
			sum = longint'(TRIG_ONE);
		return unsigned'(sum);
	endfunction

	// reciprocal table, q4.frac, rounded half up and saturated
	function automatic rom_t build_rom(input logic odd);
		rom_t        tbl;
		logic [63:0] x;
		logic [63:0] c;
		logic [63:0] v;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x = (TWO_PI_Q30 * 64'(k) + 64'(SAMPLES_PER_TURN / 2)) / SAMPLES_PER_TURN;
			c = trig_q30(x, odd);
			if (c == 64'd0) begin
				v = ROM_MAX;
			end else begin
				v = div_u64((64'd1 << (SECANT_FRAC_BITS + 30)) + (c >> 1), c);
				if (v > ROM_MAX)
					v = ROM_MAX;
			end
			tbl[k] = v[ENTRY_W-1:0];
		end
		return tbl;
	endfunction

	localparam rom_t SEC_ROM = build_rom(1'b0);
	localparam rom_t CSC_ROM = build_rom(1'b1);

endpackage

FILE: rtl/lrzc_sector.sv
// input stage: sector decode and secant / cosecant table read into the stage 1 register
`include "assert_macros.svh"

module lrzc_sector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lrzc_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lrzc_pkg::IDX_W-1:0]     sample_index,
	input  logic [lrzc_pkg::RANGE_W-1:0]   range_mm,
	input  logic                           scan_last,
	output logic                           s1_valid,
	input  logic                           s1_ready,
	output lrzc_pkg::stage1_t              s1_data
);
	import lrzc_pkg::*;

	logic [CMP_W-1:0]  idx_w;
	logic [CMP_W-1:0]  k_w;
	logic [ROM_AW-1:0] k_sel;
	logic              in_left;
	logic              in_right;
	logic              checked;
	logic              valid_s1;
	stage1_t           data_s1;

	always_comb begin
		idx_w    = CMP_W'(sample_index);
		in_left  = (idx_w << 2) < CMP_W'(SAMPLES_PER_TURN);
		in_right = ((idx_w << 2) >= CMP_W'(3 * SAMPLES_PER_TURN)) &&
		           (idx_w < CMP_W'(SAMPLES_PER_TURN));
		checked  = (in_left && cfg.left_sector_on) || (in_right && cfg.right_sector_on);
		k_w      = in_left ? idx_w : (CMP_W'(SAMPLES_PER_TURN) - idx_w);
		// unchecked samples read entry 0 so the index stays inside the table
		k_sel    = checked ? k_w[ROM_AW-1:0] : '0;
	end

	assign in_ready = !valid_s1 || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.checked   <= checked;
			data_s1.sec_entry <= SEC_ROM[k_sel];
			data_s1.csc_entry <= CSC_ROM[k_sel];
			data_s1.range_mm  <= range_mm;
			data_s1.scan_last <= scan_last;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_ready, valid_s1 && $stable(data_s1))

endmodule

FILE: rtl/lrzc_eval.sv
// result stage: zone distance, intrusion test, scan verdict and result register
`include "assert_macros.svh"

module lrzc_eval (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrzc_pkg::cfg_t                cfg,
	input  logic                          s1_valid,
	output logic                          s1_ready,
	input  lrzc_pkg::stage1_t             s1_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lrzc_pkg::DIST_W-1:0]   zone_mm,
	output logic                          intrudes,
	output logic                          scan_done,
	output logic                          go
);
	import lrzc_pkg::*;

	logic [PROD_W-1:0] prod_front;
	logic [PROD_W-1:0] prod_side;
	logic [PROD_W-1:0] shr_front;
	logic [PROD_W-1:0] shr_side;
	logic [DIST_W-1:0] dist_front;
	logic [DIST_W-1:0] dist_side;
	logic [DIST_W-1:0] zone;
	logic              hit;
	logic              hit_next;
	logic              go_next;
	logic              take;

	logic              hit_q;
	logic              go_q;
	logic              valid_s2;
	logic [DIST_W-1:0] zone_s2;
	logic              intr_s2;
	logic              done_s2;
	logic              go_s2;

	always_comb begin
		prod_front = PROD_W'(cfg.front_distance_mm) * PROD_W'(s1_data.sec_entry);
		prod_side  = PROD_W'(cfg.half_width_mm) * PROD_W'(s1_data.csc_entry);
		shr_front  = prod_front >> SECANT_FRAC_BITS;
		shr_side   = prod_side >> SECANT_FRAC_BITS;
		dist_front = (shr_front > PROD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
		                                                   : shr_front[DIST_W-1:0];
		dist_side  = (shr_side > PROD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
		                                                 : shr_side[DIST_W-1:0];
		zone       = !s1_data.checked ? '0 :
		             (dist_front < dist_side) ? dist_front : dist_side;
		hit        = s1_data.checked && (s1_data.range_mm < zone);
		hit_next   = hit_q || hit;
		go_next    = s1_data.scan_last ? !hit_next : go_q;
	end

	assign s1_ready = !valid_s2 || out_ready;
	assign take     = s1_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			hit_q    <= 1'b0;
			go_q     <= 1'b1;
		end else begin
			if (s1_ready)
				valid_s2 <= s1_valid;
			if (take) begin
				hit_q <= s1_data.scan_last ? 1'b0 : hit_next;
				go_q  <= go_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			zone_s2 <= zone;
			intr_s2 <= hit;
			done_s2 <= s1_data.scan_last;
			go_s2   <= go_next;
		end
	end

	assign out_valid = valid_s2;
	assign zone_mm   = zone_s2;
	assign intrudes  = intr_s2;
	assign scan_done = done_s2;
	assign go        = go_s2;

	`ASSERT_NEXT(a_scan_clears, clk, arst_n, take && s1_data.scan_last, !hit_q)
	`ASSERT_NEXT(a_hit_sticks, clk, arst_n, take && !s1_data.scan_last && hit, hit_q)
	`ASSERT_IMPL(a_stop_on_hit, clk, arst_n, valid_s2 && done_s2 && intr_s2, !go_s2)
	`ASSERT_IMPL(a_hit_in_zone, clk, arst_n, valid_s2 && intr_s2, zone_s2 != '0)

endmodule

FILE: rtl/lidar_rectangular_zone_check.sv
// top level: rectangular keep-out zone check over a stream of lidar range samples
// pipeline: two register stages, stage 1 then the result register; a result is offered once its beat reaches the latter
// throughput: one beat per cycle while out_ready is high; a stalled result holds both stages through the ready chain
// the secant and cosecant table read sits before stage 1, the two multiplies and compare before stage 2
// reset clears both pipeline valid bits, no intrusion seen, held verdict go_q = 1
// reset loads front 2000 mm, half width 800 mm, both sectors checked
module lidar_rectangular_zone_check (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [lrzc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrzc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// sample beat
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lrzc_pkg::IDX_W-1:0]       sample_index,
	input  logic [lrzc_pkg::RANGE_W-1:0]     range_mm,
	input  logic                             scan_last,
	// result beat
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lrzc_pkg::DIST_W-1:0]      zone_mm,
	output logic                             intrudes,
	output logic                             scan_done,
	output logic                             go
);
	import lrzc_pkg::*;

	// configuration registers; the user must write them only while the pipeline is drained, the block does not enforce it
	cfg_t    cfg_q;
	// stage 1 handshake between sector decode and evaluation
	logic    s1_valid;
	logic    s1_ready;
	stage1_t s1_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_distance_mm <= DIST_W'(2000);
			cfg_q.half_width_mm     <= DIST_W'(800);
			cfg_q.left_sector_on    <= 1'b1;
			cfg_q.right_sector_on   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRONT_DISTANCE: cfg_q.front_distance_mm <= cfg_wdata[DIST_W-1:0];
				CFG_HALF_WIDTH:     cfg_q.half_width_mm     <= cfg_wdata[DIST_W-1:0];
				CFG_LEFT_ON:        cfg_q.left_sector_on    <= cfg_wdata[0];
				CFG_RIGHT_ON:       cfg_q.right_sector_on   <= cfg_wdata[0];
				default: begin
					// unknown index: write dropped
				end
			endcase
		end
	end

	// sector decode: front-left quarter uses the index, front-right its mirror
	lrzc_sector u_sector (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_index (sample_index),
		.range_mm     (range_mm),
		.scan_last    (scan_last),
		.s1_valid     (s1_valid),
		.s1_ready     (s1_ready),
		.s1_data      (s1_data)
	);

	// zone distance is min(front * sec, half width * csc), saturated to 16 bits;
	// the scan verdict updates as each beat moves into the result register
	lrzc_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_data   (s1_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.zone_mm   (zone_mm),
		.intrudes  (intrudes),
		.scan_done (scan_done),
		.go        (go)
	);

endmodule
